// ----- rtl/sne_pkg.sv -----
package sne_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_ROWS = 4;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_SEL_W = $clog2(LINE_ROWS);
  localparam int LINE_DEPTH = LINE_ROWS * MAX_WIDTH;
  localparam int LINE_ADDR_W = ROW_SEL_W + COL_W;

  // register indexes on the configuration port
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_MASK_ROWS = 2'd3;

  localparam logic [10:0] WIDTH_RESET     = 11'd480;
  localparam logic [10:0] HEIGHT_RESET    = 11'd360;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd70;
  localparam logic [10:0] MASK_RESET      = 11'd100;

  // direction bins
  localparam logic [1:0] DIR_H    = 2'd0;
  localparam logic [1:0] DIR_D45  = 2'd1;
  localparam logic [1:0] DIR_V    = 2'd2;
  localparam logic [1:0] DIR_D135 = 2'd3;

  // Q8 tangents of 22, 66 and 68 degrees
  localparam logic [9:0] TAN22_Q8 = 10'd103;
  localparam logic [9:0] TAN66_Q8 = 10'd575;
  localparam logic [9:0] TAN68_Q8 = 10'd634;
  localparam logic [7:0] MAG_MAX  = 8'd255;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [7:0]  threshold;
    logic [10:0] mask_rows;
  } sne_cfg_t;

  typedef struct packed {
    logic             skip;
    logic             wr;
    logic             grad;
    logic             outv;
    logic             last;
    logic [10:0]      row;
    logic [COL_W-1:0] col;
    logic [10:0]      orow;
    logic [COL_W-1:0] ocol;
    logic [7:0]       pixel;
  } sne_cmd_t;

endpackage

// ----- rtl/sne_ram.sv -----
module sne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sne_front.sv -----
module sne_front import sne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  sne_cfg_t   cfg,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  logic [7:0] pixel,
  input  logic       fill,
  input  logic       q_full,
  output logic       push,
  output sne_cmd_t   cmd
);

  logic [10:0]      row;
  logic [COL_W-1:0] col;
  logic [10:0]      orow;
  logic [COL_W-1:0] ocol;
  logic             in_frame;
  logic [10:0]      col_inc;
  logic [10:0]      ocol_inc;
  logic [10:0]      row_step;
  logic [10:0]      col_step;

  assign pixel_ready = !q_full;
  assign push = pixel_valid && !q_full;
  assign in_frame = row < cfg.height;

  always_comb begin
    cmd.skip = in_frame && fill;
    cmd.wr = in_frame;
    cmd.grad = in_frame && (row >= 11'd2) && (col >= COL_W'(2));
    cmd.outv = (row > 11'd2) || ((row == 11'd2) && (col >= COL_W'(2)));
    cmd.last = (orow == cfg.height - 11'd1) && ({1'b0, ocol} == cfg.width - 11'd1);
    cmd.row = row;
    cmd.col = col;
    cmd.orow = orow;
    cmd.ocol = ocol;
    cmd.pixel = pixel;
  end

  assign col_inc = {1'b0, col} + 11'd1;
  assign ocol_inc = {1'b0, ocol} + 11'd1;

  always_comb begin
    if (col_inc >= cfg.width) begin
      col_step = 11'd0;
      row_step = row + 11'd1;
    end else begin
      col_step = col_inc;
      row_step = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
      orow <= '0;
      ocol <= '0;
    end else if (push && !cmd.skip) begin
      // restart the frame once the last output pixel has left
      if ((row_step >= cfg.height + 11'd2) && (col_step >= 11'd2)) begin
        row <= '0;
        col <= '0;
        orow <= '0;
        ocol <= '0;
      end else begin
        row <= row_step;
        col <= col_step[COL_W-1:0];
        if (cmd.outv) begin
          if (ocol_inc >= cfg.width) begin
            ocol <= '0;
            orow <= orow + 11'd1;
          end else begin
            ocol <= ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

endmodule

// ----- rtl/sne_queue.sv -----
module sne_queue import sne_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  sne_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output sne_cmd_t head
);

  sne_cmd_t   entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/sne_back.sv -----
module sne_back import sne_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sne_cfg_t cfg,
  input  logic     head_valid,
  input  sne_cmd_t head,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_ready,
  output logic     valid_res,
  output logic     edge_res,
  output logic     last_in_frame
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RD1  = 4'd2;
  localparam logic [3:0] ST_RD2  = 4'd3;
  localparam logic [3:0] ST_GRAD = 4'd4;
  localparam logic [3:0] ST_SQ   = 4'd5;
  localparam logic [3:0] ST_SUM  = 4'd6;
  localparam logic [3:0] ST_ROOT = 4'd7;
  localparam logic [3:0] ST_WB   = 4'd8;
  localparam logic [3:0] ST_EDGE = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state;
  sne_cmd_t   cur;

  logic [7:0] pw [3][3];
  logic [7:0] mw [3][3];
  logic [7:0] pix_a;
  logic [7:0] mag_a;
  logic [1:0] dir_c;

  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic [19:0] sqx;
  logic [20:0] sum;
  logic [1:0]  dir_new;
  logic [7:0]  root;
  logic [2:0]  bitn;
  logic        res_v;
  logic        res_e;
  logic        res_l;

  // line store ports
  logic [LINE_ADDR_W-1:0] pix_raddr;
  logic [LINE_ADDR_W-1:0] mag_raddr;
  logic [LINE_ADDR_W-1:0] dir_raddr;
  logic [LINE_ADDR_W-1:0] pix_waddr;
  logic [LINE_ADDR_W-1:0] mag_waddr;
  logic [7:0]             pix_rdata;
  logic [7:0]             mag_rdata;
  logic [1:0]             dir_rdata;
  logic                   pix_we;
  logic                   mag_we;
  logic [7:0]             mag_new;

  logic [10:0]      row_m1;
  logic [10:0]      row_m2;
  logic [10:0]      orow_m1;
  logic [COL_W-1:0] ocol_p1;
  logic [COL_W-1:0] col_m1;

  assign row_m1 = cur.row - 11'd1;
  assign row_m2 = cur.row - 11'd2;
  assign orow_m1 = cur.orow - 11'd1;
  assign ocol_p1 = cur.ocol + COL_W'(1);
  assign col_m1 = cur.col - COL_W'(1);

  always_comb begin
    if (state == ST_RD1) begin
      pix_raddr = {row_m2[ROW_SEL_W-1:0], cur.col};
      mag_raddr = {cur.orow[ROW_SEL_W-1:0], ocol_p1};
    end else begin
      pix_raddr = {row_m1[ROW_SEL_W-1:0], cur.col};
      mag_raddr = {orow_m1[ROW_SEL_W-1:0], ocol_p1};
    end
    dir_raddr = {cur.orow[ROW_SEL_W-1:0], cur.ocol};
    pix_waddr = {cur.row[ROW_SEL_W-1:0], cur.col};
    mag_waddr = {row_m1[ROW_SEL_W-1:0], col_m1};
  end

  assign pix_we = (state == ST_RD2) && cur.wr;
  assign mag_we = (state == ST_WB) && cur.grad;
  assign mag_new = (sum[20:16] != 5'd0) ? MAG_MAX : root;

  sne_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_pix_ram (
    .clk  (clk),
    .we   (pix_we),
    .waddr(pix_waddr),
    .wdata(cur.pixel),
    .raddr(pix_raddr),
    .rdata(pix_rdata)
  );

  sne_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_mag_ram (
    .clk  (clk),
    .we   (mag_we),
    .waddr(mag_waddr),
    .wdata(mag_new),
    .raddr(mag_raddr),
    .rdata(mag_rdata)
  );

  sne_ram #(.WIDTH(2), .DEPTH(LINE_DEPTH)) u_dir_ram (
    .clk  (clk),
    .we   (mag_we),
    .waddr(mag_waddr),
    .wdata(dir_new),
    .raddr(dir_raddr),
    .rdata(dir_rdata)
  );

  // Sobel sums
  logic [9:0] left_sum;
  logic [9:0] right_sum;
  logic [9:0] top_sum;
  logic [9:0] bot_sum;

  assign left_sum  = {2'd0, pw[0][0]} + {1'b0, pw[1][0], 1'b0} + {2'd0, pw[2][0]};
  assign right_sum = {2'd0, pw[0][2]} + {1'b0, pw[1][2], 1'b0} + {2'd0, pw[2][2]};
  assign top_sum   = {2'd0, pw[0][0]} + {1'b0, pw[0][1], 1'b0} + {2'd0, pw[0][2]};
  assign bot_sum   = {2'd0, pw[2][0]} + {1'b0, pw[2][1], 1'b0} + {2'd0, pw[2][2]};

  logic signed [11:0] gx_neg;
  logic signed [11:0] gy_neg;
  logic [9:0]  ax;
  logic [9:0]  ay;
  logic [9:0]  axd;
  logic [19:0] ang;
  logic [19:0] t22;
  logic [19:0] t66;
  logic [19:0] t68;
  logic        neg;
  logic [1:0]  dir_calc;

  assign gx_neg = -gx;
  assign gy_neg = -gy;
  assign ax = gx[11] ? gx_neg[9:0] : gx[9:0];
  assign ay = gy[11] ? gy_neg[9:0] : gy[9:0];
  assign axd = (gx == 12'sd0) ? 10'd1 : ax;
  assign ang = {2'd0, ay, 8'd0};
  assign t22 = 20'(axd * TAN22_Q8);
  assign t66 = 20'(axd * TAN66_Q8);
  assign t68 = 20'(axd * TAN68_Q8);
  assign neg = (gy != 12'sd0) && (gy[11] != gx[11]);

  always_comb begin
    if (ang <= t22) begin
      dir_calc = DIR_H;
    end else if (neg) begin
      dir_calc = (ang <= t66) ? DIR_D135 : DIR_V;
    end else begin
      dir_calc = (ang <= t68) ? DIR_D45 : DIR_V;
    end
  end

  // one root bit per cycle
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  assign trial = root | (8'd1 << bitn);
  assign trial_sq = trial * trial;

  // non-maximum suppression over the magnitude window
  logic       interior;
  logic       top_b;
  logic       bot_b;
  logic       lft_b;
  logic       rgt_b;
  logic [7:0] nm [3][3];
  logic [7:0] n1;
  logic [7:0] n2;
  logic [7:0] g_kept;
  logic       edge_calc;

  always_comb begin
    interior = (cur.orow != 11'd0) && (cur.ocol != '0) &&
               (cur.orow < cfg.height - 11'd1) && ({1'b0, cur.ocol} < cfg.width - 11'd1);
    top_b = cur.orow == 11'd1;
    bot_b = cur.orow == cfg.height - 11'd2;
    lft_b = cur.ocol == COL_W'(1);
    rgt_b = {1'b0, cur.ocol} == cfg.width - 11'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nm[i][j] = ((i == 0 && top_b) || (i == 2 && bot_b) ||
                    (j == 0 && lft_b) || (j == 2 && rgt_b)) ? 8'd0 : mw[i][j];
      end
    end
    unique case (dir_c)
      DIR_H: begin
        n1 = nm[1][2];
        n2 = nm[1][0];
      end
      DIR_D45: begin
        n1 = nm[0][2];
        n2 = nm[2][0];
      end
      DIR_V: begin
        n1 = nm[0][1];
        n2 = nm[2][1];
      end
      default: begin
        n1 = nm[2][2];
        n2 = nm[0][0];
      end
    endcase
    g_kept = (mw[1][1] > n1 && mw[1][1] > n2) ? mw[1][1] : 8'd0;
    edge_calc = interior && (cur.orow >= cfg.mask_rows) && (g_kept >= cfg.threshold);
  end

  assign pop = (state == ST_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            state <= head.skip ? ST_DONE : ST_RD0;
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: state <= ST_RD2;
        ST_RD2: state <= cur.grad ? ST_GRAD : ST_WB;
        ST_GRAD: state <= ST_SQ;
        ST_SQ: state <= ST_SUM;
        ST_SUM: state <= ST_ROOT;
        ST_ROOT: begin
          if (bitn == 3'd0) begin
            state <= ST_WB;
          end
        end
        ST_WB: state <= ST_EDGE;
        ST_EDGE: state <= ST_DONE;
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur <= head;
        res_v <= 1'b0;
        res_e <= 1'b0;
        res_l <= 1'b0;
      end
      ST_RD1: begin
        pix_a <= pix_rdata;
        mag_a <= mag_rdata;
        dir_c <= dir_rdata;
      end
      ST_RD2: begin
        // advance the pixel window by one column
        if (cur.wr) begin
          for (int i = 0; i < 3; i++) begin
            pw[i][0] <= pw[i][1];
            pw[i][1] <= pw[i][2];
          end
          pw[0][2] <= pix_rdata;
          pw[1][2] <= pix_a;
          pw[2][2] <= cur.pixel;
        end
        mag_a <= mag_a;
        pix_a <= mag_rdata;
      end
      ST_GRAD: begin
        gx <= $signed({2'd0, left_sum}) - $signed({2'd0, right_sum});
        gy <= $signed({2'd0, top_sum}) - $signed({2'd0, bot_sum});
      end
      ST_SQ: begin
        sqx <= ax * ax;
        dir_new <= dir_calc;
      end
      ST_SUM: begin
        sum <= {1'b0, sqx} + 21'(ay * ay);
        root <= 8'd0;
        bitn <= 3'd7;
      end
      ST_ROOT: begin
        if (trial_sq <= sum[15:0]) begin
          root <= trial;
        end
        bitn <= bitn - 3'd1;
      end
      ST_WB: begin
        // advance the magnitude window; the new column's lower entry is this gradient
        if (cur.outv) begin
          for (int i = 0; i < 3; i++) begin
            mw[i][0] <= mw[i][1];
            mw[i][1] <= mw[i][2];
          end
          mw[0][2] <= mag_a;
          mw[1][2] <= pix_a;
          mw[2][2] <= cur.grad ? mag_new : 8'd0;
        end
      end
      ST_EDGE: begin
        res_v <= cur.outv;
        res_e <= cur.outv && edge_calc;
        res_l <= cur.outv && cur.last;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          valid_res <= res_v;
          edge_res <= res_e;
          last_in_frame <= res_l;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/sobel_nms_edge_detector_core.sv -----
// Sequence: a pixel that forms a gradient steps through read, gradient, square,
// sum, bit-serial root, write-back, edge and done states; other pixels skip the
// gradient, square, sum and root states, and a skipped fill item goes to done.
// The back-end sequencer takes a new item only after the last one leaves done.
// Reset: synchronous, active high; clears counters, queue and handshakes and
// loads register defaults. Line stores have no reset and need no clearing pass.
module sobel_nms_edge_detector_core import sne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel channel
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [7:0]  pixel,
  input  logic        fill,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic        valid_res,
  output logic        edge_res,
  output logic        last_in_frame,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [7:0]  edge_threshold;
  logic [10:0] masked_top_rows;
  logic        cfg_write;
  sne_cfg_t    cfg;

  sne_cmd_t push_cmd;
  sne_cmd_t head;
  logic     push;
  logic     q_full;
  logic     head_valid;
  logic     pop;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // register file; any write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      edge_threshold <= THRESHOLD_RESET;
      masked_top_rows <= MASK_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_WIDTH:     image_width <= pwdata[10:0];
        REG_HEIGHT:    image_height <= pwdata[10:0];
        REG_THRESHOLD: edge_threshold <= pwdata[7:0];
        REG_MASK_ROWS: masked_top_rows <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:     prdata = {21'd0, image_width};
      REG_HEIGHT:    prdata = {21'd0, image_height};
      REG_THRESHOLD: prdata = {24'd0, edge_threshold};
      REG_MASK_ROWS: prdata = {21'd0, masked_top_rows};
      default:       prdata = '0;
    endcase
  end

  // clamp the frame size to what the line stores hold
  always_comb begin
    if (image_width < 11'd3) begin
      cfg.width = 11'd3;
    end else if (image_width > 11'(MAX_WIDTH)) begin
      cfg.width = 11'(MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height < 11'd3) begin
      cfg.height = 11'd3;
    end else if (image_height > 11'(MAX_HEIGHT)) begin
      cfg.height = 11'(MAX_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.threshold = edge_threshold;
    cfg.mask_rows = masked_top_rows;
  end

  // front: accept and classify each transaction, track raster positions
  sne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .cfg        (cfg),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .fill       (fill),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // short queue decouples acceptance from processing
  sne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  // back: line stores, gradient, root, suppression, output register
  sne_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res),
    .edge_res     (edge_res),
    .last_in_frame(last_in_frame)
  );

endmodule

// ----- tb/tb_sobel_nms_edge_detector_core.sv -----
module tb_sobel_nms_edge_detector_core;
  import sne_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected edge map of the stream, kept one transaction at a time.
  class edge_scoreboard;
    typedef struct {
      bit v;
      bit e;
      bit l;
    } edge_out_t;

    edge_out_t   expected_q[$];
    bit [7:0]    pix_ln[LINE_ROWS][MAX_WIDTH];
    bit [7:0]    mag_ln[LINE_ROWS][MAX_WIDTH];
    bit [1:0]    dir_ln[LINE_ROWS][MAX_WIDTH];
    int unsigned row_cnt, col_cnt;
    int unsigned width_reg, height_reg, thr_reg, mask_reg;
    int          errors, results, edges, lasts, fills_in_frame;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      thr_reg    = THRESHOLD_RESET;
      mask_reg   = MASK_RESET;
    endfunction

    function int unsigned eff_w();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // Any register write restarts the frame.
    function void write_reg(logic [1:0] idx, int unsigned val);
      int unsigned v;
      v = val & 'h7FF;
      case (idx)
        REG_WIDTH:     width_reg = v;
        REG_HEIGHT:    height_reg = v;
        REG_THRESHOLD: thr_reg = v & 'hFF;
        default:       mask_reg = v;
      endcase
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    function void form_gradient(int unsigned y, int unsigned x);
      int          p[3][3];
      int          gx, gy;
      int unsigned ax, ay, s, root, trial, a;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p[i][j] = pix_ln[(y - 1 + i) % LINE_ROWS][x - 1 + j];
      gx = p[0][0] + 2 * p[1][0] + p[2][0] - p[0][2] - 2 * p[1][2] - p[2][2];
      gy = p[0][0] + 2 * p[0][1] + p[0][2] - p[2][0] - 2 * p[2][1] - p[2][2];
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      s = ax * ax + ay * ay;
      root = 0;
      if (s >= 65536) begin
        root = MAG_MAX;
      end else begin
        for (int b = 7; b >= 0; b--) begin
          trial = root | (1 << b);
          if (trial * trial <= s) root = trial;
        end
      end
      mag_ln[y % LINE_ROWS][x] = 8'(root);
      // vertical gradient counts as a unit horizontal one
      if (gx == 0) begin
        gx = 1;
        ax = 1;
      end
      a = ay * 256;
      if (a <= TAN22_Q8 * ax)
        dir_ln[y % LINE_ROWS][x] = DIR_H;
      else if (gy != 0 && ((gy < 0) != (gx < 0)))
        dir_ln[y % LINE_ROWS][x] = (a <= TAN66_Q8 * ax) ? DIR_D135 : DIR_V;
      else
        dir_ln[y % LINE_ROWS][x] = (a <= TAN68_Q8 * ax) ? DIR_D45 : DIR_V;
    endfunction

    function int unsigned mag_of(int unsigned y, int unsigned x, int unsigned w,
                                 int unsigned h);
      if (y == 0 || x == 0 || y >= h - 1 || x >= w - 1) return 0;
      return mag_ln[y % LINE_ROWS][x];
    endfunction

    function bit edge_of(int unsigned y, int unsigned x, int unsigned w, int unsigned h);
      int unsigned g, n1, n2;
      if (y == 0 || x == 0 || y >= h - 1 || x >= w - 1) return 0;
      if (y < mask_reg) return 0;
      g = mag_of(y, x, w, h);
      case (dir_ln[y % LINE_ROWS][x])
        DIR_H: begin
          n1 = mag_of(y, x + 1, w, h);
          n2 = mag_of(y, x - 1, w, h);
        end
        DIR_D45: begin
          n1 = mag_of(y - 1, x + 1, w, h);
          n2 = mag_of(y + 1, x - 1, w, h);
        end
        DIR_V: begin
          n1 = mag_of(y - 1, x, w, h);
          n2 = mag_of(y + 1, x, w, h);
        end
        default: begin
          n1 = mag_of(y + 1, x + 1, w, h);
          n2 = mag_of(y - 1, x - 1, w, h);
        end
      endcase
      if (!(g > n1 && g > n2)) g = 0;
      return g >= thr_reg;
    endfunction

    function void note_input(bit [7:0] p, bit f);
      edge_out_t   r_exp;
      int unsigned w, h, r, c, n, m;
      w = eff_w();
      h = eff_h();
      r = row_cnt;
      c = col_cnt;
      n = r * w + c;
      r_exp = '{0, 0, 0};
      if (r < h) begin
        // fill inside the frame: drop it, state holds
        if (f) begin
          fills_in_frame++;
          expected_q.push_back(r_exp);
          return;
        end
        pix_ln[r % LINE_ROWS][c] = p;
        if (r >= 2 && c >= 2) form_gradient(r - 1, c - 1);
      end
      if (n >= 2 * w + 2) begin
        m = n - (2 * w + 2);
        r_exp.v = 1;
        r_exp.e = edge_of(m / w, m % w, w, h);
        r_exp.l = (m == w * h - 1);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h + 2 && c >= 2) begin
        r = 0;
        c = 0;
      end
      row_cnt = r;
      col_cnt = c;
      expected_q.push_back(r_exp);
    endfunction

    function void check_result(bit v, bit e, bit l);
      edge_out_t r_exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction valid_res=%0b edge_res=%0b last=%0b",
                 $time, v, e, l);
        errors++;
        return;
      end
      r_exp = expected_q.pop_front();
      results++;
      edges += e;
      lasts += l;
      if (r_exp.v !== v) begin
        $display("%0t: valid_res expected %0b actual %0b", $time, r_exp.v, v);
        errors++;
      end
      if (r_exp.e !== e) begin
        $display("%0t: edge_res expected %0b actual %0b", $time, r_exp.e, e);
        errors++;
      end
      if (r_exp.l !== l) begin
        $display("%0t: last_in_frame expected %0b actual %0b", $time, r_exp.l, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        pixel_valid;
  logic        pixel_ready;
  logic [7:0]  pixel;
  logic        fill;
  logic        result_valid;
  logic        result_ready;
  logic        valid_res;
  logic        edge_res;
  logic        last_in_frame;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  edge_scoreboard sb = new();

  // idle rates in percent, and a long receiver hold-off counted in cycles
  int send_idle;
  int recv_idle;
  int hold_left;
  int holds;
  int sent;
  int frames_sent;
  int cfg_writes;

  sobel_nms_edge_detector_core u_dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel(pixel), .fill(fill),
    .result_valid(result_valid), .result_ready(result_ready),
    .valid_res(valid_res), .edge_res(edge_res), .last_in_frame(last_in_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Predict on every accepted pixel transaction, check every accepted result.
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) sb.note_input(pixel, fill);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      sb.check_result(valid_res, edge_res, last_in_frame);
  end

  // Receiver: random back-pressure, or a solid hold-off when one is requested.
  initial begin
    result_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one pixel transaction and hold it until accepted. Valid stays high
  // across back-to-back transactions; drop it only while idling.
  task automatic send_item(input logic [7:0] p, input logic f);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      pixel_valid <= 0;
      @(negedge clk);
    end
    pixel_valid <= 1;
    pixel <= p;
    fill <= f;
    do @(posedge clk); while (!pixel_ready);
    sent++;
  endtask

  // Wait out every outstanding result and the back end's tail latency.
  task automatic drain_block();
    @(negedge clk);
    pixel_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Write a register with the block idle, then read it back.
  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    int unsigned want;
    drain_block();
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    pwrite <= 0;
    penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    want = (idx == REG_THRESHOLD) ? (val & 'hFF) : (val & 'h7FF);
    if (prdata !== want) begin
      $display("%0t: register %0d readback expected %0h actual %0h", $time, idx, want,
               prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  // One frame in raster order, then its drain. Pixel style: 0 random, 1 binary
  // levels for strong edges, 2 ramps plus noise. cut stops the frame early.
  task automatic send_frame(input int style, input int fill_pct, input int cut);
    int unsigned w, h, total;
    logic [7:0]  p;
    w = sb.eff_w();
    h = sb.eff_h();
    total = w * h;
    for (int unsigned k = 0; k < total; k++) begin
      if (cut > 0 && k == cut) return;
      if ($urandom_range(99) < fill_pct) send_item(8'($urandom), 1'b1);
      case (style)
        0: p = 8'($urandom);
        1: p = $urandom_range(1) ? 8'd255 : 8'd0;
        default: p = 8'((k % w) * 37 + (k / w) * 11 + $urandom_range(15));
      endcase
      send_item(p, 1'b0);
    end
    // drain items: usually marked, sometimes left as noise pixels
    for (int unsigned k = 0; k < 2 * w + 2; k++)
      send_item(8'($urandom), ($urandom_range(9) != 0));
    frames_sent++;
  endtask

  initial begin
    int unsigned w, h;
    rst = 1;
    pixel_valid = 0;
    pixel = 0;
    fill = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_left = 0;
    holds = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: 3x3 frame, zero threshold, no mask, extreme pixels, a fill
    // inside the frame and drain items, alternately unmarked and marked.
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 3);
    cfg_write(REG_THRESHOLD, 0);
    cfg_write(REG_MASK_ROWS, 0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    for (int k = 0; k < 8; k++) send_item(8'h55, k[0]);
    // a mask past the frame blanks everything; then full threshold
    cfg_write(REG_MASK_ROWS, 'h7FF);
    send_frame(1, 0, 0);
    cfg_write(REG_MASK_ROWS, 0);
    cfg_write(REG_THRESHOLD, 255);
    send_frame(0, 0, 0);

    // Random frames; idle profile changes with progress.
    while (sent < 600) begin
      if (sent < 200) begin
        send_idle = 22;
        recv_idle = 59;
      end else if (sent < 400) begin
        send_idle = 59;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(1)) begin
        // sizes below 3 get clamped by the block
        w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
        h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
      end
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: cfg_write(REG_THRESHOLD, 0);
          1: cfg_write(REG_THRESHOLD, $urandom_range(255));
          default: cfg_write(REG_THRESHOLD, $urandom_range(20, 120));
        endcase
      end
      if ($urandom_range(2) == 0)
        cfg_write(REG_MASK_ROWS, ($urandom_range(7) == 0) ? $urandom_range(2047) :
                                 $urandom_range(3));
      if (sent >= 250 && holds == 0) begin
        hold_left = 300;
        holds++;
      end
      if ($urandom_range(9) == 0) begin
        // broken frame: stop part way, a register write restarts the frame
        send_frame($urandom_range(2), 5, $urandom_range(1, 12));
        cfg_write(REG_THRESHOLD, sb.thr_reg);
      end else begin
        send_frame($urandom_range(2), 4, 0);
      end
    end

    // Size extremes, cut short: widest line (clamped), then tallest frame at
    // minimum width.
    cfg_write(REG_WIDTH, 'h7FF);
    cfg_write(REG_HEIGHT, 3);
    cfg_write(REG_MASK_ROWS, 0);
    cfg_write(REG_THRESHOLD, 40);
    send_frame(2, 0, 120);
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 'h7FF);
    send_frame(1, 1, 100);
    cfg_write(REG_HEIGHT, 1024);
    cfg_write(REG_WIDTH, 1024);
    cfg_write(REG_MASK_ROWS, 1024);

    drain_block();
    $display("Covered %0d pixel transactions in %0d frames, %0d register writes,",
             sent, frames_sent, cfg_writes);
    $display("%0d results checked (%0d edges, %0d frame ends), %0d fills in frame.",
             sb.results, sb.edges, sb.lasts, sb.fills_in_frame);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
